@@ src/tfs_pkg.sv @@
// ----------------------------------------------------------------------------
// tfs_pkg
// Types, constants and helpers shared by the trilinear force splat block.
// ----------------------------------------------------------------------------
`default_nettype none

package tfs_pkg;

  localparam int GRID_SIZE = 32;
  localparam int GB        = $clog2(GRID_SIZE);
  localparam int CELL_AW   = 3 * GB;
  localparam int CELLS     = GRID_SIZE * GRID_SIZE * GRID_SIZE;

  // kinds of request
  localparam logic [1:0] KIND_SPLAT = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // result status codes
  localparam logic [1:0] ST_APPLIED = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_READ    = 2'd2;
  localparam logic [1:0] ST_CLEARED = 2'd3;

  // configuration register indexes
  localparam logic CFG_INV_SPACING  = 1'b0;
  localparam logic CFG_DOMAIN_LIMIT = 1'b1;

  localparam logic [23:0] INV_SPACING_RST  = 24'd65536;
  localparam logic [23:0] DOMAIN_LIMIT_RST = 24'd2097152;

  typedef struct packed {
    logic [1:0]         kind;
    logic [23:0]        pos_x;
    logic [23:0]        pos_y;
    logic [23:0]        pos_z;
    logic signed [15:0] push_x;
    logic signed [15:0] push_y;
    logic signed [15:0] push_z;
  } tfs_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] cell_x;
    logic signed [31:0] cell_y;
    logic signed [31:0] cell_z;
  } tfs_out_t;

  // operation decoded by the front end
  typedef enum logic [1:0] {
    OP_SPLAT = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_DROP  = 2'd3
  } tfs_op_t;

  // classified request held in the queue
  typedef struct packed {
    tfs_op_t            op;
    logic [GB-1:0]      cx;
    logic [GB-1:0]      cy;
    logic [GB-1:0]      cz;
    logic               rd_ok;
    logic [15:0]        fx;
    logic [15:0]        fy;
    logic [15:0]        fz;
    logic signed [15:0] push_x;
    logic signed [15:0] push_y;
    logic signed [15:0] push_z;
  } tfs_cmd_t;

  localparam int QDEPTH = 2;

endpackage

`default_nettype wire

@@ src/tfs_front.sv @@
// ----------------------------------------------------------------------------
// tfs_front
// Accepts requests, checks the domain, scales positions into grid units and
// pushes a classified command into a short queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tfs_front import tfs_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire tfs_in_t  in_data,
  input  wire logic [23:0] inv_spacing,
  input  wire logic [23:0] domain_limit,
  output logic          cmd_valid,
  input  wire logic     cmd_pop,
  output tfs_cmd_t      cmd
);

  // stage 1: request register and three scaling products
  logic          s1_valid_r;
  tfs_in_t       s1_r;
  logic [47:0]   gx_r, gy_r, gz_r;
  logic          s1_out_r;
  logic          s1_go;

  // queue
  tfs_cmd_t               q_r [QDEPTH];
  logic [$clog2(QDEPTH):0] cnt_r;
  logic [$clog2(QDEPTH)-1:0] wp_r, rp_r;
  logic push, pop;
  tfs_cmd_t c_nxt;

  // stage 1 moves on only if the queue has room for it
  assign s1_go    = s1_valid_r && (cnt_r < ($clog2(QDEPTH)+1)'(QDEPTH));
  assign in_stall = s1_valid_r && !s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
    if (!in_stall && in_valid) begin
      s1_r     <= in_data;
      gx_r     <= in_data.pos_x * inv_spacing;
      gy_r     <= in_data.pos_y * inv_spacing;
      gz_r     <= in_data.pos_z * inv_spacing;
      s1_out_r <= (in_data.pos_x > domain_limit) || (in_data.pos_y > domain_limit) ||
                  (in_data.pos_z > domain_limit);
    end
  end

  // classify
  always_comb begin
    c_nxt        = '0;
    c_nxt.push_x = s1_r.push_x;
    c_nxt.push_y = s1_r.push_y;
    c_nxt.push_z = s1_r.push_z;
    c_nxt.op     = OP_DROP;
    case (s1_r.kind)
      KIND_SPLAT: begin
        c_nxt.cx = gx_r[32 +: GB];
        c_nxt.cy = gy_r[32 +: GB];
        c_nxt.cz = gz_r[32 +: GB];
        c_nxt.fx = gx_r[31:16];
        c_nxt.fy = gy_r[31:16];
        c_nxt.fz = gz_r[31:16];
        if (!s1_out_r && (gx_r[47:32] < 16'(GRID_SIZE)) && (gy_r[47:32] < 16'(GRID_SIZE))
            && (gz_r[47:32] < 16'(GRID_SIZE))) begin
          c_nxt.op = OP_SPLAT;
        end
      end
      KIND_READ: begin
        c_nxt.op    = OP_READ;
        c_nxt.cx    = s1_r.pos_x[GB-1:0];
        c_nxt.cy    = s1_r.pos_y[GB-1:0];
        c_nxt.cz    = s1_r.pos_z[GB-1:0];
        c_nxt.rd_ok = (s1_r.pos_x < 24'(GRID_SIZE)) && (s1_r.pos_y < 24'(GRID_SIZE)) &&
                      (s1_r.pos_z < 24'(GRID_SIZE));
      end
      KIND_CLEAR: c_nxt.op = OP_CLEAR;
      default:    c_nxt.op = OP_DROP;
    endcase
  end

  assign push      = s1_go;
  assign pop       = cmd_pop && (cnt_r != '0);
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= '0;
      rp_r  <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + ($clog2(QDEPTH)+1)'(push) - ($clog2(QDEPTH)+1)'(pop);
    end
    if (push) q_r[wp_r] <= c_nxt;
  end

endmodule

`default_nettype wire

@@ src/tfs_back.sv @@
// ----------------------------------------------------------------------------
// tfs_back
// Carries out commands against the grid memory: splats as a sequence of
// read-modify-writes, reads, and a clearing sweep. Holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tfs_back import tfs_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cmd_valid,
  output logic          cmd_pop,
  input  wire tfs_cmd_t cmd,
  output logic          out_valid,
  input  wire logic     out_stall,
  output tfs_out_t      out_data
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_WGT   = 7'b0000010,
    S_RD    = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_WR    = 7'b0010000,
    S_RDOUT = 7'b0100000,
    S_CLEAR = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  tfs_cmd_t c_r;
  logic [1:0] comp_r;
  logic [2:0] corner_r;
  logic [CELL_AW-1:0] clr_r;
  logic [1:0] rdc_r;
  logic init_r;

  // grid memory, one bank per component
  logic [31:0] mem0 [CELLS];
  logic [31:0] mem1 [CELLS];
  logic [31:0] mem2 [CELLS];
  logic [31:0] rd0_r, rd1_r, rd2_r;
  logic [CELL_AW-1:0] raddr, waddr_r;
  logic we;
  logic [1:0] wcomp;
  logic [31:0] wdata;

  // weights
  logic [31:0] wxy_r;
  logic [15:0] wz_r;
  logic [48:0] w_r;
  logic [16:0] wx, wy, wz;
  logic [GB:0] ix, iy, iz;
  logic skip;

  logic signed [15:0] force_c;
  logic signed [65:0] prod_r;
  logic signed [33:0] add;
  logic [65:0] mag;
  logic [33:0] rnd;
  logic signed [33:0] sum;
  logic [31:0] cur;

  // result register
  logic out_valid_r;
  tfs_out_t out_r;
  logic done;
  tfs_out_t res;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // corner coordinates and axis weights
  assign ix = {1'b0, c_r.cx} + (GB+1)'(corner_r[0]);
  assign iy = {1'b0, c_r.cy} + (GB+1)'(corner_r[1]);
  assign iz = {1'b0, c_r.cz} + (GB+1)'(corner_r[2]);
  assign wx = corner_r[0] ? {1'b0, c_r.fx} : 17'h10000 - {1'b0, c_r.fx};
  assign wy = corner_r[1] ? {1'b0, c_r.fy} : 17'h10000 - {1'b0, c_r.fy};
  assign wz = corner_r[2] ? {1'b0, c_r.fz} : 17'h10000 - {1'b0, c_r.fz};
  assign skip = ix[GB] || iy[GB] || iz[GB];

  assign force_c = (comp_r == 2'd0) ? c_r.push_x :
                   (comp_r == 2'd1) ? c_r.push_y : c_r.push_z;

  // memory read address
  always_comb begin
    raddr = {iz[GB-1:0], iy[GB-1:0], ix[GB-1:0]};
    if (state_r == S_RDOUT) raddr = {c_r.cz, c_r.cy, c_r.cx};
  end

  always_ff @(posedge clk) begin
    rd0_r <= mem0[raddr];
    rd1_r <= mem1[raddr];
    rd2_r <= mem2[raddr];
  end

  // rounding and saturating add
  always_comb begin
    mag  = prod_r[65] ? 66'(-prod_r) : 66'(prod_r);
    rnd  = 34'((mag + 66'h80000000) >> 32);
    add  = prod_r[65] ? -$signed(rnd) : $signed(rnd);
    cur  = (comp_r == 2'd0) ? rd0_r : (comp_r == 2'd1) ? rd1_r : rd2_r;
    sum  = $signed({{2{cur[31]}}, cur}) + add;
    if (sum > 34'sh07FFFFFFF)       wdata = 32'h7FFFFFFF;
    else if (sum < -34'sh080000000) wdata = 32'h80000000;
    else                            wdata = sum[31:0];
  end

  always_comb begin
    we    = 1'b0;
    wcomp = comp_r;
    if (state_r == S_WR) we = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) begin
      mem0[clr_r] <= '0;
      mem1[clr_r] <= '0;
      mem2[clr_r] <= '0;
    end else if (we) begin
      if (wcomp == 2'd0) mem0[waddr_r] <= wdata;
      if (wcomp == 2'd1) mem1[waddr_r] <= wdata;
      if (wcomp == 2'd2) mem2[waddr_r] <= wdata;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cmd_pop   = 1'b0;
    done      = 1'b0;
    res       = '0;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid && !out_valid_r) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            OP_SPLAT: state_nxt = S_WGT;
            OP_READ:  state_nxt = S_RDOUT;
            OP_CLEAR: state_nxt = S_CLEAR;
            default: begin
              done       = 1'b1;
              res.status = ST_DROPPED;
            end
          endcase
        end
      end
      S_WGT: begin
        state_nxt = skip ? S_WGT : S_RD;
        // a skipped final corner ends the splat
        if (skip && comp_r == 2'd2 && corner_r == 3'd7) begin
          state_nxt  = S_IDLE;
          done       = 1'b1;
          res.status = ST_APPLIED;
        end
      end
      S_RD:  state_nxt = S_MUL;
      S_MUL: state_nxt = S_WR;
      S_WR: begin
        state_nxt = S_WGT;
        if (comp_r == 2'd2 && corner_r == 3'd7) begin
          state_nxt  = S_IDLE;
          done       = 1'b1;
          res.status = ST_APPLIED;
        end
      end
      S_RDOUT: begin
        if (rdc_r == 2'd1) begin
          state_nxt  = S_IDLE;
          done       = 1'b1;
          res.status = ST_READ;
          if (c_r.rd_ok) begin
            res.cell_x = rd0_r;
            res.cell_y = rd1_r;
            res.cell_z = rd2_r;
          end
        end
      end
      S_CLEAR: begin
        if (clr_r == CELL_AW'(CELLS-1)) begin
          state_nxt  = S_IDLE;
          // the sweep after reset returns no result
          done       = !init_r;
          res.status = ST_CLEARED;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      init_r      <= 1'b1;
      out_valid_r <= 1'b0;
      comp_r      <= '0;
      corner_r    <= '0;
      clr_r       <= '0;
      rdc_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (done) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          comp_r   <= '0;
          corner_r <= '0;
          clr_r    <= '0;
          rdc_r    <= '0;
        end
        S_WGT: begin
          // skipped corners advance without a memory access
          if (skip) begin
            corner_r <= corner_r + 1'b1;
            if (corner_r == 3'd7) comp_r <= comp_r + 1'b1;
          end
        end
        S_WR: begin
          corner_r <= corner_r + 1'b1;
          if (corner_r == 3'd7) comp_r <= comp_r + 1'b1;
        end
        S_RDOUT: rdc_r <= rdc_r + 1'b1;
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == CELL_AW'(CELLS-1)) init_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && cmd_pop) c_r <= cmd;
    if (done) out_r <= res;
    if (state_r == S_WGT) begin
      wxy_r   <= wx * wy;
      wz_r    <= wz[15:0];
      waddr_r <= raddr;
    end
    if (state_r == S_RD) begin
      // 33x17 product gives the Q1.48 corner weight
      w_r <= 49'(({1'b0, wxy_r} + (wxy_r == 32'd0 && (wx[16] && wy[16]) ? 33'h100000000 : 33'd0))
             * {(wz_r == 16'd0 && wz[16]), wz_r});
    end
    if (state_r == S_MUL) prod_r <= force_c * $signed({1'b0, w_r});
  end

endmodule

`default_nettype wire

@@ src/trilinear_force_splat_top.sv @@
// ----------------------------------------------------------------------------
// trilinear_force_splat_top
// Trilinear force splatting into a 32x32x32 grid of saturating accumulators.
// ----------------------------------------------------------------------------
// A splat steps through each of three components and, for each, its corners;
// a corner inside the grid goes through the weight, read, multiply and write
// states, while a corner past the grid edge only passes the weight state with
// no memory access; a single read-modify-write sequencer on the grid memory
// runs all of it. A read goes through the read-out state, a drop ends in the
// idle state, and a clear sweeps one cell per cycle. The front end scales and
// classifies while the back end works; a two-entry queue sits between them.
// After reset the back end sweeps the grid to zero with no result; requests
// sent meanwhile wait in the front end.
`default_nettype none

module trilinear_force_splat_top import tfs_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire tfs_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output tfs_out_t      out_data,
  input  wire logic     cfg_we,
  input  wire logic     cfg_index,
  input  wire logic [23:0] cfg_data
);

  logic [23:0] inv_spacing_r, domain_limit_r;
  logic        cmd_valid, cmd_pop;
  tfs_cmd_t    cmd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_spacing_r  <= INV_SPACING_RST;
      domain_limit_r <= DOMAIN_LIMIT_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_INV_SPACING)  inv_spacing_r  <= cfg_data;
      if (cfg_index == CFG_DOMAIN_LIMIT) domain_limit_r <= cfg_data;
    end
  end

  tfs_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .inv_spacing(inv_spacing_r), .domain_limit(domain_limit_r),
    .cmd_valid, .cmd_pop, .cmd
  );

  tfs_back u_back (
    .clk, .rst_n, .cmd_valid, .cmd_pop, .cmd,
    .out_valid, .out_stall, .out_data
  );

endmodule

`default_nettype wire

@@ src/tfs_checker.sv @@
// ----------------------------------------------------------------------------
// tfs_checker
// Port-level checks on the trilinear force splat block.
// ----------------------------------------------------------------------------
`default_nettype none

module tfs_checker import tfs_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire tfs_out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");

  // a stalled request stays offered
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid)
    else $error("request dropped under stall");

  // read status comes with no stray data on other statuses
  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_READ |->
      out_data.cell_x == 0 && out_data.cell_y == 0 && out_data.cell_z == 0)
    else $error("data on non-read result");

  // nothing comes out right after reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

  // input never stalls right out of reset
  a_rst_ready: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("stall after reset");

endmodule

bind trilinear_force_splat_top tfs_checker u_tfs_checker (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);

`default_nettype wire
